### sv/swbqc_pkg.sv
package swbqc_pkg;

  // Default sizing of the history memory and of the running total.
  localparam int DEF_MAX_WINDOW  = 1024;
  localparam int DEF_TOTAL_WIDTH = 24;

  // Fixed field widths.
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 11;
  localparam int CNT_W     = 11;
  localparam int MATCH_W   = 24;
  localparam int REG_IDX_W = 3;
  localparam int NUM_BASES = 4;

  // Reset value of the window length register.
  localparam logic [CFG_W-1:0] DEF_WINDOW_LENGTH = 11'd4;

  // Saturation limit of a base count.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // ASCII codes of the recognized bases.
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

  // Two-bit base codes kept in the history memory.
  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_t;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_MIN_A         = 3'd1,
    REG_MIN_C         = 3'd2,
    REG_MIN_G         = 3'd3,
    REG_MIN_T         = 3'd4
  } reg_idx_t;

  // Map an ASCII character to a base code; anything unrecognized is a T.
  function automatic base_t char_to_base(input logic [CHAR_W-1:0] ch);
    base_t b;
    case (ch)
      CHAR_A:  b = BASE_A;
      CHAR_C:  b = BASE_C;
      CHAR_G:  b = BASE_G;
      default: b = BASE_T;
    endcase
    return b;
  endfunction

endpackage

### sv/sliding_window_base_quota_counter.sv
// Counts A, C, G and T over a sliding window of the last window_length
// characters of a string and reports, for every character item, whether the
// window is full, whether every count meets its minimum, and a saturating
// total of qualifying windows so far in the string. Characters other than
// A, C and G count as T. The block takes one item per cycle while the output
// is not stalled, with a read stage and an output register; the base codes of
// the window live in a one-port-write, one-port-read memory of MAX_WINDOW
// two-bit entries, read at acceptance and bypassed when the write of the previous
// item hits the same entry. An item with tlast ends the string and clears the
// counts, the fill level and the total; writing window_length restarts the string
// as well. Length zero acts as one, and lengths above MAX_WINDOW as MAX_WINDOW.
// Users must write configuration only while idle; the block does not enforce it.
module sliding_window_base_quota_counter #(
  parameter int MAX_WINDOW  = swbqc_pkg::DEF_MAX_WINDOW,
  parameter int TOTAL_WIDTH = swbqc_pkg::DEF_TOTAL_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [swbqc_pkg::CHAR_W-1:0]        in_tdata,   // [7:0] base_char
  input  logic                                in_tlast,   // end_of_string
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [0] window_valid,
                                                          // [1] window_meets_quota,
                                                          // [25:2] match_total,
                                                          // [31:26] zero
  output logic                                out_tlast,  // is_last
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [swbqc_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [swbqc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (SW > swbqc_pkg::CFG_W) ? SW : swbqc_pkg::CFG_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_WINDOW);
  localparam logic [CW-1:0] EFF_RESET =
    (CW'(swbqc_pkg::DEF_WINDOW_LENGTH) > MAX_LEN) ? MAX_LEN
                                                   : CW'(swbqc_pkg::DEF_WINDOW_LENGTH);
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  // Configuration registers.
  logic [CW-1:0]                    eff_len_r;
  logic [swbqc_pkg::CNT_W-1:0]      min_cnt_r [swbqc_pkg::NUM_BASES];

  // Front stage: pointer and fill level.
  logic [AW-1:0]                    ptr_r;
  logic [CW-1:0]                    seen_r;

  // Read stage registers.
  logic                             s1_valid_r;
  logic [AW-1:0]                    s1_ptr_r;
  swbqc_pkg::base_t                 s1_code_r;
  logic                             s1_last_r;
  logic                             s1_remove_r;
  logic                             s1_full_r;
  logic                             fwd_r;
  swbqc_pkg::base_t                 fwd_code_r;
  logic [1:0]                       rd_data_r;

  // Update stage state.
  logic [swbqc_pkg::CNT_W-1:0]      cnt_r [swbqc_pkg::NUM_BASES];
  logic [TOTAL_WIDTH-1:0]           total_r;

  // Output register.
  logic                             out_valid_r;
  logic                             out_full_r;
  logic                             out_meets_r;
  logic [swbqc_pkg::MATCH_W-1:0]    out_total_r;
  logic                             out_last_r;

  // History memory of base codes.
  logic [1:0]                       hist_mem [MAX_WINDOW];

  logic                             advance;
  logic                             accept;
  logic [CW-1:0]                    cur_ptr;
  logic [CW-1:0]                    ptr_inc;
  logic [AW-1:0]                    ptr_nxt;
  logic [CW-1:0]                    seen_nxt;
  swbqc_pkg::base_t                 in_code;
  logic [CW-1:0]                    wr_len;
  logic [1:0]                       old_code;
  logic [swbqc_pkg::CNT_W-1:0]      cnt_nxt [swbqc_pkg::NUM_BASES];
  logic                             meets;
  logic [TOTAL_WIDTH-1:0]           total_nxt;
  logic [31:0]                      total_ext;

  // Handshake: the read stage moves on whenever the output register is free.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  // Front stage: slot to overwrite, next pointer and fill level.
  always_comb begin
    cur_ptr  = (CW'(ptr_r) >= eff_len_r) ? '0 : CW'(ptr_r);
    ptr_inc  = cur_ptr + CW'(1);
    ptr_nxt  = (ptr_inc >= eff_len_r) ? '0 : ptr_inc[AW-1:0];
    seen_nxt = (seen_r < eff_len_r) ? seen_r + CW'(1) : seen_r;
    in_code  = swbqc_pkg::char_to_base(in_tdata);
  end

  // Clamped window length for a configuration write.
  always_comb begin
    if (cfg_wdata == '0) begin
      wr_len = CW'(1);
    end else if (CW'(cfg_wdata) > MAX_LEN) begin
      wr_len = MAX_LEN;
    end else begin
      wr_len = CW'(cfg_wdata);
    end
  end

  // Update stage: remove the leaving base, add the entering one, check quota.
  always_comb begin
    logic [swbqc_pkg::CNT_W-1:0] trimmed;
    old_code = fwd_r ? fwd_code_r : rd_data_r;
    meets    = s1_full_r;
    for (int i = 0; i < swbqc_pkg::NUM_BASES; i++) begin
      trimmed = cnt_r[i];
      if (s1_remove_r && old_code == 2'(i) && cnt_r[i] != '0) begin
        trimmed = cnt_r[i] - swbqc_pkg::CNT_W'(1);
      end
      cnt_nxt[i] = trimmed;
      if (s1_code_r == 2'(i) && trimmed != swbqc_pkg::CNT_MAX) begin
        cnt_nxt[i] = trimmed + swbqc_pkg::CNT_W'(1);
      end
      if (cnt_nxt[i] < min_cnt_r[i]) begin
        meets = 1'b0;
      end
    end
    total_nxt = (meets && total_r != TOTAL_MAX) ? total_r + TOTAL_WIDTH'(1) : total_r;
    total_ext = 32'(total_nxt);
  end

  // History memory: write back in the update stage, read in the front stage.
  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      hist_mem[s1_ptr_r] <= s1_code_r;
    end
    if (accept) begin
      rd_data_r  <= hist_mem[cur_ptr[AW-1:0]];
      fwd_r      <= s1_valid_r && advance && (s1_ptr_r == cur_ptr[AW-1:0]);
      fwd_code_r <= s1_code_r;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ptr_r    <= cur_ptr[AW-1:0];
      s1_code_r   <= in_code;
      s1_last_r   <= in_tlast;
      s1_remove_r <= (seen_r >= eff_len_r);
      s1_full_r   <= (seen_nxt >= eff_len_r);
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_full_r  <= s1_full_r;
      out_meets_r <= meets;
      out_total_r <= total_ext[swbqc_pkg::MATCH_W-1:0];
      out_last_r  <= s1_last_r;
    end
  end

  // Control state, configuration and string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_len_r   <= EFF_RESET;
      for (int i = 0; i < swbqc_pkg::NUM_BASES; i++) begin
        min_cnt_r[i] <= '0;
        cnt_r[i]     <= '0;
      end
      ptr_r       <= '0;
      seen_r      <= '0;
      total_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Front stage.
      if (accept) begin
        ptr_r  <= in_tlast ? '0 : ptr_nxt;
        seen_r <= in_tlast ? '0 : seen_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      // Update stage.
      if (s1_valid_r && advance) begin
        for (int i = 0; i < swbqc_pkg::NUM_BASES; i++) begin
          cnt_r[i] <= s1_last_r ? '0 : cnt_nxt[i];
        end
        total_r <= s1_last_r ? '0 : total_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end

      // Configuration writes; a new window length restarts the string.
      if (cfg_we) begin
        case (swbqc_pkg::reg_idx_t'(cfg_addr))
          swbqc_pkg::REG_WINDOW_LENGTH: begin
            eff_len_r <= wr_len;
            ptr_r     <= '0;
            seen_r    <= '0;
            total_r   <= '0;
            for (int i = 0; i < swbqc_pkg::NUM_BASES; i++) begin
              cnt_r[i] <= '0;
            end
          end
          swbqc_pkg::REG_MIN_A: min_cnt_r[swbqc_pkg::BASE_A] <= cfg_wdata;
          swbqc_pkg::REG_MIN_C: min_cnt_r[swbqc_pkg::BASE_C] <= cfg_wdata;
          swbqc_pkg::REG_MIN_G: min_cnt_r[swbqc_pkg::BASE_G] <= cfg_wdata;
          swbqc_pkg::REG_MIN_T: min_cnt_r[swbqc_pkg::BASE_T] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_total_r, out_meets_r, out_full_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The write pointer always lies inside the current window.
  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(ptr_r) < eff_len_r)
    else $error("write pointer outside window");

  // The fill level never passes the window length.
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= eff_len_r)
    else $error("fill level beyond window length");

  // A window can only meet quota once it is full.
  a_meets_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_full_r || !out_meets_r))
    else $error("quota met on a partial window");

  // While the end-of-string result waits, the string state is already clear.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (total_r == '0 && cnt_r[0] == '0 &&
      cnt_r[1] == '0 && cnt_r[2] == '0 && cnt_r[3] == '0))
    else $error("string state not cleared after last item");
`endif

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swbqc_pkg::*;

  // Run length and watchdog.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_WAIT  = 4;
  localparam int unsigned TAIL_WAIT    = 10;
  localparam int unsigned PHASE_ITEMS  = 210;
  localparam int unsigned LONG_STRING  = 64;
  localparam int unsigned REPORT_LIMIT = 10;

  // Largest value of the running total.
  localparam int unsigned TOTAL_MAX = (1 << DEF_TOTAL_WIDTH) - 1;

  // The package has no T; any other byte maps to T as well.
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  // Register indexes past the end of the register list.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Minimum-count register of each base code.
  localparam reg_idx_t MIN_REG [NUM_BASES] = '{REG_MIN_A, REG_MIN_C, REG_MIN_G, REG_MIN_T};

  // One result item as the block reports it.
  typedef struct packed {
    logic               win_valid;
    logic               quota_met;
    logic [MATCH_W-1:0] match_total;
    logic               is_last;
  } window_result_t;

  // One line of the directed stimulus: a register write or a character.
  typedef struct {
    bit                   is_reg;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [CHAR_W-1:0]    ch;
    logic                 eos;
    bit                   typed;
    window_result_t       want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [CHAR_W-1:0]    in_tdata;   // [7:0] base_char
  logic                 in_tlast;   // end_of_string
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;  // [0] window_valid, [1] window_meets_quota,
                                    // [25:2] match_total, [31:26] zero
  logic                 out_tlast;  // is_last
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  sliding_window_base_quota_counter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Window state tracked alongside the block.
  logic [CFG_W-1:0] span_reg;
  logic [CFG_W-1:0] need [NUM_BASES];
  base_t            history [DEF_MAX_WINDOW];
  int unsigned      wr_pos;
  int unsigned      fill;
  int unsigned      tally [NUM_BASES];
  int unsigned      qualified;

  window_result_t window_q [$];
  stim_row_t      directed_rows [$];
  int unsigned    mismatches = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a missing result ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Effective window length after clamping.
  function automatic int unsigned window_span();
    if (span_reg == '0) return 1;
    if (span_reg > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
    return span_reg;
  endfunction

  // A new string starts with empty counts and a zero total.
  function automatic void restart_string();
    wr_pos = 0;
    fill = 0;
    qualified = 0;
    for (int b = 0; b < NUM_BASES; b++) tally[b] = 0;
  endfunction

  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      REG_WINDOW_LENGTH: begin
        span_reg = val;
        restart_string();
      end
      REG_MIN_A: need[BASE_A] = val;
      REG_MIN_C: need[BASE_C] = val;
      REG_MIN_G: need[BASE_G] = val;
      REG_MIN_T: need[BASE_T] = val;
      default: ;
    endcase
  endfunction

  // Advance the window by one character and work out its result.
  function automatic window_result_t step_window(input logic [CHAR_W-1:0] ch,
                                                 input logic eos);
    window_result_t r;
    int unsigned    span;
    int unsigned    pos;
    base_t          code;
    base_t          leaving;
    span = window_span();
    if (ch == CHAR_A) code = BASE_A;
    else if (ch == CHAR_C) code = BASE_C;
    else if (ch == CHAR_G) code = BASE_G;
    else code = BASE_T;
    pos = (wr_pos >= span) ? 0 : wr_pos;
    // The oldest character drops out once the window is full.
    if (fill >= span) begin
      leaving = history[pos];
      if (tally[leaving] > 0) tally[leaving]--;
    end
    if (tally[code] < CNT_MAX) tally[code]++;
    history[pos] = code;
    wr_pos = (pos + 1 >= span) ? 0 : pos + 1;
    if (fill < span) fill++;
    r.win_valid = (fill >= span);
    r.quota_met = r.win_valid;
    for (int b = 0; b < NUM_BASES; b++) begin
      if (tally[b] < need[b]) r.quota_met = 1'b0;
    end
    if (r.quota_met && qualified < TOTAL_MAX) qualified++;
    r.match_total = qualified[MATCH_W-1:0];
    r.is_last = eos;
    if (eos) restart_string();
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [REG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t ch_row(input logic [CHAR_W-1:0] ch, input logic eos);
    stim_row_t r;
    r = '{default: '0};
    r.ch = ch;
    r.eos = eos;
    return r;
  endfunction

  function automatic stim_row_t ch_exp(input logic [CHAR_W-1:0] ch, input logic eos,
                                       input logic v, input logic m,
                                       input logic [MATCH_W-1:0] tot);
    stim_row_t r;
    r = ch_row(ch, eos);
    r.typed = 1'b1;
    r.want = '{v, m, tot, eos};
    return r;
  endfunction

  // Mostly real bases, with some arbitrary bytes that count as T.
  function automatic logic [CHAR_W-1:0] random_char();
    case ($urandom_range(0, 11))
      0, 1:    return CHAR_W'($urandom_range(0, 255));
      2, 3, 4: return CHAR_A;
      5, 6:    return CHAR_C;
      7, 8:    return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endtask

  // Offer one character item; the sender may idle before it.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eos,
                           input bit typed, input window_result_t want);
    window_result_t predicted;
    bit             took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= eos;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    predicted = step_window(ch, eos);
    window_q.push_back(typed ? want : predicted);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic settle_stream();
    in_tvalid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  // Pick a new window and quotas near the counts a window of that size holds.
  task automatic shuffle_settings();
    int unsigned span;
    settle_stream();
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0:       write_reg(REG_WINDOW_LENGTH, '0);
        1:       write_reg(REG_WINDOW_LENGTH, CFG_W'(1));
        default: write_reg(REG_WINDOW_LENGTH, CFG_W'($urandom_range(2, 12)));
      endcase
    end
    span = window_span();
    for (int b = 0; b < NUM_BASES; b++) begin
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 7) == 0)
          write_reg(MIN_REG[b], CFG_W'($urandom_range(0, 2047)));
        else
          write_reg(MIN_REG[b], CFG_W'($urandom_range(0, span / 4 + 1)));
      end
    end
    if ($urandom_range(0, 9) == 0)
      write_reg(REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_W'($urandom_range(0, 2047)));
  endtask

  // Random strings, most of them closed by an end-of-string item.
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned str_len;
    bit          closes;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 1) != 0) shuffle_settings();
      str_len = $urandom_range(1, 3 * window_span() + 4);
      closes = ($urandom_range(0, 7) != 0);
      for (int unsigned k = 0; k < str_len; k++)
        send_char(random_char(), closes && (k == str_len - 1), 1'b0, '0);
      sent += str_len;
    end
  endtask

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(negedge clk) begin
    window_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (window_q.size() == 0) begin
        flag_mismatch("result with no item pending", '0, out_tdata);
      end else begin
        want = window_q.pop_front();
        if (out_tdata[0] !== want.win_valid)
          flag_mismatch("window_valid", want.win_valid, out_tdata[0]);
        if (out_tdata[1] !== want.quota_met)
          flag_mismatch("window_meets_quota", want.quota_met, out_tdata[1]);
        if (out_tdata[25:2] !== want.match_total)
          flag_mismatch("match_total", want.match_total, out_tdata[25:2]);
        if (out_tlast !== want.is_last)
          flag_mismatch("is_last", want.is_last, out_tlast);
        if (out_tdata[31:26] !== '0)
          flag_mismatch("tdata padding", '0, out_tdata[31:26]);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    span_reg = DEF_WINDOW_LENGTH;
    for (int b = 0; b < NUM_BASES; b++) need[b] = '0;
    restart_string();

    // Default window of four, no quotas: every full window qualifies.
    directed_rows.push_back(ch_exp(CHAR_A, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_C, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_G, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_T, 1'b0, 1'b1, 1'b1, 24'd1));
    directed_rows.push_back(ch_exp(8'h00, 1'b0, 1'b1, 1'b1, 24'd2));
    directed_rows.push_back(ch_exp(8'hFF, 1'b1, 1'b1, 1'b1, 24'd3));
    // Largest A quota can never be met; lowercase a counts as T.
    directed_rows.push_back(reg_row(REG_MIN_A, 11'h7FF));
    directed_rows.push_back(ch_exp(8'h61, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_A, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_A, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_A, 1'b1, 1'b1, 1'b0, 24'd0));
    // Writes past the register list must change nothing.
    directed_rows.push_back(reg_row(REG_SPARE_LO, 11'h7FF));
    directed_rows.push_back(reg_row(REG_SPARE_HI, 11'h7FF));
    // Zero window length behaves as a window of one.
    directed_rows.push_back(reg_row(REG_MIN_A, '0));
    directed_rows.push_back(reg_row(REG_WINDOW_LENGTH, '0));
    directed_rows.push_back(ch_exp(CHAR_C, 1'b0, 1'b1, 1'b1, 24'd1));
    directed_rows.push_back(ch_exp(CHAR_G, 1'b1, 1'b1, 1'b1, 24'd2));
    // Largest window stays unfilled over a short string.
    directed_rows.push_back(reg_row(REG_WINDOW_LENGTH, 11'd1024));
    directed_rows.push_back(ch_exp(CHAR_T, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_A, 1'b1, 1'b0, 1'b0, 24'd0));
    // Rewriting the window length mid-string restarts the string.
    directed_rows.push_back(reg_row(REG_WINDOW_LENGTH, 11'd3));
    directed_rows.push_back(reg_row(REG_MIN_C, 11'd1));
    directed_rows.push_back(reg_row(REG_MIN_G, 11'd1));
    directed_rows.push_back(ch_row(CHAR_A, 1'b0));
    directed_rows.push_back(ch_row(CHAR_C, 1'b0));
    directed_rows.push_back(reg_row(REG_WINDOW_LENGTH, 11'd3));
    directed_rows.push_back(ch_exp(CHAR_G, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_exp(CHAR_T, 1'b0, 1'b0, 1'b0, 24'd0));
    directed_rows.push_back(ch_row(CHAR_C, 1'b0));
    directed_rows.push_back(ch_row(CHAR_A, 1'b0));
    directed_rows.push_back(ch_row(CHAR_G, 1'b1));
    directed_rows.push_back(reg_row(REG_MIN_T, 11'd1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow sender, heavily stalled receiver.
    send_idle_pct = 31;
    recv_idle_pct = 82;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        settle_stream();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_char(directed_rows[i].ch, directed_rows[i].eos,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end
    run_phase(PHASE_ITEMS);

    // Bursty sender, mostly ready receiver.
    send_idle_pct = 82;
    recv_idle_pct = 31;
    run_phase(PHASE_ITEMS);

    // Full rate, starting with one string over an oversized, clamped window.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle_stream();
    write_reg(REG_WINDOW_LENGTH, 11'h7FF);
    for (int b = 0; b < NUM_BASES; b++)
      write_reg(MIN_REG[b], CFG_W'($urandom_range(150, 200)));
    for (int unsigned k = 0; k < LONG_STRING; k++)
      send_char(random_char(), k == LONG_STRING - 1, 1'b0, '0);
    settle_stream();
    write_reg(REG_WINDOW_LENGTH, 11'd6);
    run_phase(PHASE_ITEMS);

    settle_stream();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
